>>> rtl/core/xycv_pkg.sv
// ----------------------------------------------------------------------------
// xycv_pkg
// Shared widths, constants, lane structs and the smoother coefficient table
// builder for the XY CV smooth/quantize block.
// ----------------------------------------------------------------------------
package xycv_pkg;

  // default build settings
  localparam int SAMPLE_RATE_DEF   = 48000;
  localparam int ALPHA_ENTRIES_DEF = 256;

  // field widths
  localparam int PosW     = 17;
  localparam int VinW     = 17;
  localparam int VoutW    = 19;
  localparam int KnobW    = 17;
  localparam int LevelW   = 17;
  localparam int GateW    = 16;
  localparam int QmodeW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;
  localparam int SmW      = 28;
  localparam int NoteW    = 12;
  localparam int AlphaW   = 25;

  // output voltage limit, Q12
  localparam logic signed [VoutW-1:0] VLIM = 19'sd139264;
  localparam logic signed [NoteW-1:0] NOTE_RESET = -12'sd1200;
  localparam logic [AlphaW-1:0] ONE_Q24 = 25'd16777216;

  // reciprocals for constant division: ceil(2^24/10), ceil(2^21/3)
  localparam logic [20:0] RECIP10 = 21'd1677722;
  localparam logic [20:0] RECIP3  = 21'd699051;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_SMOOTH_LEVEL  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUANTIZE_MODE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_X_LOWER_KNOB  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_X_UPPER_KNOB  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_Y_LOWER_KNOB  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_Y_UPPER_KNOB  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_GATE_SAMPLES  = 3'd6;

  // operands handed to one axis lane
  typedef struct packed {
    logic [PosW-1:0]         pos;
    logic signed [KnobW-1:0] lo_knob;
    logic signed [KnobW-1:0] hi_knob;
    logic signed [VinW-1:0]  lo_cv;
    logic signed [VinW-1:0]  hi_cv;
    logic signed [VinW-1:0]  mod;
    logic                    quant;
    logic [GateW-1:0]        gate_len;
  } lane_in_t;

  // what one lane found for the current item
  typedef struct packed {
    logic signed [VoutW-1:0] value;
    logic                    gate;
  } lane_out_t;

  // shift-subtract divide, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // coefficient 1 - exp(-T / (2 s^2)) in Q24 for entry i, s = i / n1
  function automatic logic [AlphaW-1:0] make_alpha(input logic [63:0] i,
                                                   input logic [63:0] n1,
                                                   input logic [63:0] rate);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] xq;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] e;
    logic signed [63:0] sum;
    logic [63:0] res;
    num = n1 * n1;
    den = 64'd2 * i * i * rate;
    // short time constants bypass the smoother
    if (i == 64'd0 || 64'd20000 * i * i < num || den == 64'd0) begin
      return ONE_Q24;
    end
    xq = udiv64(num << 30, den);
    y  = xq >> 4;
    if (y >= (64'd1 << 30)) begin
      return ONE_Q24;
    end
    term = 64'd1 << 30;
    sum  = $signed(term);
    // Taylor series of exp(-x/16)
    for (int k = 1; k <= 16; k++) begin
      term = udiv64((term * y) >> 30, 64'(k));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    e = (sum < 0) ? 64'd0 : 64'(sum);
    // raise to the 16th power
    for (int k = 0; k < 4; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    if (e > (64'd1 << 30)) begin
      e = 64'd1 << 30;
    end
    res = ((64'd1 << 30) - e + 64'd32) >> 6;
    return res[AlphaW-1:0];
  endfunction

endpackage

>>> rtl/core/xycv_if.sv
// ----------------------------------------------------------------------------
// xycv_in_if / xycv_out_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface xycv_in_if;
  import xycv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PosW-1:0]        pos_x;
  logic [PosW-1:0]        pos_y;
  logic signed [VinW-1:0] mod_x;
  logic signed [VinW-1:0] mod_y;
  logic signed [VinW-1:0] x_lower_cv;
  logic signed [VinW-1:0] x_upper_cv;
  logic signed [VinW-1:0] y_lower_cv;
  logic signed [VinW-1:0] y_upper_cv;
  logic signed [VinW-1:0] smooth_cv;

  modport source (output valid, pos_x, pos_y, mod_x, mod_y, x_lower_cv, x_upper_cv,
                  y_lower_cv, y_upper_cv, smooth_cv, input ready);
  modport sink   (input valid, pos_x, pos_y, mod_x, mod_y, x_lower_cv, x_upper_cv,
                  y_lower_cv, y_upper_cv, smooth_cv, output ready);
  modport mon    (input valid, ready, pos_x, pos_y, mod_x, mod_y, x_lower_cv,
                  x_upper_cv, y_lower_cv, y_upper_cv, smooth_cv);
endinterface

interface xycv_out_if;
  import xycv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VoutW-1:0] out_x;
  logic signed [VoutW-1:0] out_y;
  logic                    gate_x;
  logic                    gate_y;

  modport source (output valid, out_x, out_y, gate_x, gate_y, input ready);
  modport sink   (input valid, out_x, out_y, gate_x, gate_y, output ready);
  modport mon    (input valid, ready, out_x, out_y, gate_x, gate_y);
endinterface

>>> rtl/core/xycv_alpha_unit.sv
// ----------------------------------------------------------------------------
// xycv_alpha_unit
// Works out the smoothness from knob plus CV/10, clamps it, scales it to a
// table index and reads the smoother coefficient from a registered ROM.
// ----------------------------------------------------------------------------
module xycv_alpha_unit #(
  parameter int SAMPLE_RATE_HZ      = xycv_pkg::SAMPLE_RATE_DEF,
  parameter int ALPHA_TABLE_ENTRIES = xycv_pkg::ALPHA_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [xycv_pkg::LevelW-1:0]        smooth_level,
  input  logic signed [xycv_pkg::VinW-1:0]   smooth_cv,
  output logic [xycv_pkg::AlphaW-1:0]        alpha,
  output logic                               done
);
  import xycv_pkg::*;

  localparam int IdxW  = $clog2(ALPHA_TABLE_ENTRIES);
  localparam int ProdW = LevelW + IdxW;
  localparam logic [IdxW-1:0]  LastIdx   = IdxW'(ALPHA_TABLE_ENTRIES - 1);
  localparam logic [ProdW-1:0] HalfRound = ProdW'(32768);
  localparam logic [LevelW-1:0] LevelOne = 17'd65536;

  localparam logic [2:0] STP_RECIP = 3'd1;
  localparam logic [2:0] STP_CLAMP = 3'd2;
  localparam logic [2:0] STP_SCALE = 3'd3;
  localparam logic [2:0] STP_READ  = 3'd4;

  // coefficient ROM, one constant per entry
  logic [AlphaW-1:0] rom_w [ALPHA_TABLE_ENTRIES];
  for (genvar g = 0; g < ALPHA_TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [AlphaW-1:0] Entry =
      make_alpha(64'(g), 64'(ALPHA_TABLE_ENTRIES - 1), 64'(SAMPLE_RATE_HZ));
    assign rom_w[g] = Entry;
  end

  logic              active_r;
  logic [2:0]        step_r;
  logic              done_r;
  logic              neg_r;
  logic [20:0]       mag_r;
  logic [41:0]       mul_r;
  logic [LevelW-1:0] s16_r;
  logic [ProdW-1:0]  im_r;
  logic [AlphaW-1:0] alpha_r;

  // |cv|*16 + 5, the rounding bias for the divide by ten
  logic signed [VinW:0] cv_ext;
  logic [VinW:0]        cv_abs;
  logic [20:0]          mag_nxt;
  always_comb begin
    cv_ext  = {smooth_cv[VinW-1], smooth_cv};
    cv_abs  = smooth_cv[VinW-1] ? (VinW+1)'(-cv_ext) : cv_ext;
    mag_nxt = 21'({cv_abs, 4'd0}) + 21'd5;
  end

  // knob plus signed quotient, clamped to [0, one]
  logic signed [18:0] q_s;
  logic signed [18:0] s_sum;
  logic [LevelW-1:0]  s16_nxt;
  always_comb begin
    q_s   = $signed({1'b0, mul_r[41:24]});
    s_sum = $signed({2'b00, smooth_level}) + (neg_r ? -q_s : q_s);
    if (s_sum < 0) begin
      s16_nxt = '0;
    end else if (s_sum > $signed({2'b00, LevelOne})) begin
      s16_nxt = LevelOne;
    end else begin
      s16_nxt = s_sum[LevelW-1:0];
    end
  end

  // table index with a guard against overrun
  logic [IdxW:0]   idx_full;
  logic [IdxW-1:0] idx_sel;
  always_comb begin
    idx_full = im_r[ProdW-1:16];
    idx_sel  = (idx_full > {1'b0, LastIdx}) ? LastIdx : idx_full[IdxW-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        step_r   <= STP_RECIP;
      end else if (active_r) begin
        if (step_r == STP_READ) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag_nxt;
      neg_r <= smooth_cv[VinW-1];
    end else if (active_r) begin
      case (step_r)
        STP_RECIP: mul_r   <= mag_r * RECIP10;
        STP_CLAMP: s16_r   <= s16_nxt;
        STP_SCALE: im_r    <= ProdW'(s16_r) * ProdW'(LastIdx) + HalfRound;
        STP_READ:  alpha_r <= rom_w[idx_sel];
        default: ;
      endcase
    end
  end

  assign alpha = alpha_r;
  assign done  = done_r;

endmodule

>>> rtl/core/xycv_axis_lane.sv
// ----------------------------------------------------------------------------
// xycv_axis_lane
// One axis: range map, offset, one-pole smoother, semitone rounding and the
// note-change gate counter. Runs as an eight-step sequence with at most one
// multiply per step.
// ----------------------------------------------------------------------------
module xycv_axis_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  xycv_pkg::lane_in_t          lane_in,
  input  logic [xycv_pkg::AlphaW-1:0] alpha,
  output xycv_pkg::lane_out_t         result,
  output logic                        done
);
  import xycv_pkg::*;

  localparam logic [3:0] STP_RANGE  = 4'd1;
  localparam logic [3:0] STP_TARGET = 4'd2;
  localparam logic [3:0] STP_DIFF   = 4'd3;
  localparam logic [3:0] STP_ALPHA  = 4'd4;
  localparam logic [3:0] STP_ACCUM  = 4'd5;
  localparam logic [3:0] STP_NOTE   = 4'd6;
  localparam logic [3:0] STP_RECIP  = 4'd7;
  localparam logic [3:0] STP_OUT    = 4'd8;

  localparam logic signed [VoutW-1:0] VLIM_NEG = -VLIM;

  function automatic logic signed [VoutW-1:0] sat_v(input logic signed [23:0] x);
    if (x > 24'(VLIM)) begin
      return VLIM;
    end
    if (x < 24'(VLIM_NEG)) begin
      return VLIM_NEG;
    end
    return x[VoutW-1:0];
  endfunction

  logic                    active_r;
  logic [3:0]              step_r;
  logic                    done_r;
  logic signed [18:0]      lo_r;
  logic signed [19:0]      diff_r;
  logic signed [37:0]      prod_r;
  logic signed [VoutW-1:0] t_r;
  logic signed [28:0]      d_r;
  logic signed [54:0]      prod2_r;
  logic signed [SmW-1:0]   sm_r;
  logic signed [NoteW-1:0] note_r;
  logic signed [VoutW-1:0] plain_r;
  logic [42:0]             q3_r;
  logic signed [NoteW-1:0] last_r;
  logic [GateW-1:0]        left_r;
  lane_out_t               res_r;

  // range limits: knob plus CV
  logic signed [18:0] lo_w;
  logic signed [18:0] hi_w;
  always_comb begin
    lo_w = 19'(lane_in.lo_knob) + 19'(lane_in.lo_cv);
    hi_w = 19'(lane_in.hi_knob) + 19'(lane_in.hi_cv);
  end

  // target = lo + round(pos*diff / 2^16) + mod, saturated
  logic signed [37:0]     prod_adj;
  logic signed [21:0]     rnd_w;
  logic signed [23:0]     t_sum;
  always_comb begin
    prod_adj = prod_r + $signed(38'd32768) - $signed({37'd0, prod_r[37]});
    rnd_w    = $signed(prod_adj[37:16]);
    t_sum    = 24'(lo_r) + 24'(rnd_w) + 24'(lane_in.mod);
  end

  // smoother step: sm += round(d*alpha / 2^24)
  logic signed [54:0] prod2_adj;
  logic signed [30:0] inc_w;
  logic signed [30:0] sm_sum;
  always_comb begin
    prod2_adj = prod2_r + $signed(55'd8388608) - $signed({54'd0, prod2_r[54]});
    inc_w     = $signed(prod2_adj[54:24]);
    sm_sum    = 31'(sm_r) + inc_w;
  end

  // note = round(sm*12 / 2^20), plain = round(sm / 256)
  logic signed [31:0]    sm12;
  logic signed [31:0]    sm12_adj;
  logic signed [SmW-1:0] sm_adj;
  logic signed [23:0]    plain_w;
  always_comb begin
    sm12     = (32'(sm_r) <<< 3) + (32'(sm_r) <<< 2);
    sm12_adj = sm12 + $signed(32'd524288) - $signed({31'd0, sm12[31]});
    sm_adj   = sm_r + $signed(28'd128) - $signed({27'd0, sm_r[SmW-1]});
    plain_w  = 24'($signed(sm_adj[SmW-1:8]));
  end

  // |note|*1024 + 1 for the divide by three
  logic [NoteW-1:0] note_abs;
  logic [21:0]      mag3;
  always_comb begin
    note_abs = note_r[NoteW-1] ? NoteW'(-note_r) : note_r;
    mag3     = {note_abs, 10'd0} + 22'd1;
  end

  // quantized value, output select and gate counter
  logic signed [23:0]      qv;
  logic signed [VoutW-1:0] v_w;
  logic                    retrig;
  logic [GateW-1:0]        left_a;
  logic                    gate_w;
  always_comb begin
    qv     = note_r[NoteW-1] ? -24'($signed({1'b0, q3_r[42:21]}))
                             : 24'($signed({1'b0, q3_r[42:21]}));
    v_w    = lane_in.quant ? sat_v(qv) : plain_r;
    retrig = lane_in.quant && (note_r != last_r) && (left_r < lane_in.gate_len);
    left_a = retrig ? lane_in.gate_len : left_r;
    gate_w = (left_a != '0);
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        step_r   <= STP_RANGE;
      end else if (active_r) begin
        if (step_r == STP_OUT) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end else begin
          step_r <= step_r + 4'd1;
        end
      end
    end
  end

  // axis state: smoother, last note, pulse count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_r   <= '0;
      last_r <= NOTE_RESET;
      left_r <= '0;
    end else if (active_r && !start) begin
      if (step_r == STP_ACCUM) begin
        sm_r <= sm_sum[SmW-1:0];
      end
      if (step_r == STP_OUT) begin
        last_r <= note_r;
        left_r <= gate_w ? left_a - GateW'(1) : left_a;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      lo_r   <= lo_w;
      diff_r <= 20'(hi_w) - 20'(lo_w);
    end else if (active_r) begin
      case (step_r)
        STP_RANGE:  prod_r  <= $signed({1'b0, lane_in.pos}) * diff_r;
        STP_TARGET: t_r     <= sat_v(t_sum);
        STP_DIFF:   d_r     <= 29'($signed({t_r, 8'd0})) - 29'(sm_r);
        STP_ALPHA:  prod2_r <= d_r * $signed({1'b0, alpha});
        STP_NOTE: begin
          note_r  <= $signed(sm12_adj[31:20]);
          plain_r <= sat_v(plain_w);
        end
        STP_RECIP:  q3_r    <= mag3 * RECIP3;
        STP_OUT: begin
          res_r.value <= v_w;
          res_r.gate  <= gate_w;
        end
        default: ;
      endcase
    end
  end

  assign result = res_r;
  assign done   = done_r;

endmodule

>>> rtl/core/xycv_merge.sv
// ----------------------------------------------------------------------------
// xycv_merge
// Joins the two lane results into one result item and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module xycv_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  xycv_pkg::lane_out_t lane_x,
  input  xycv_pkg::lane_out_t lane_y,
  output logic                free,
  xycv_out_if.source          out_if
);
  import xycv_pkg::*;

  logic                    valid_r;
  logic signed [VoutW-1:0] out_x_r;
  logic signed [VoutW-1:0] out_y_r;
  logic                    gate_x_r;
  logic                    gate_y_r;

  // slot is free when empty or being taken this cycle
  assign free = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r  <= lane_x.value;
      out_y_r  <= lane_y.value;
      gate_x_r <= lane_x.gate;
      gate_y_r <= lane_y.gate;
    end
  end

  assign out_if.valid  = valid_r;
  assign out_if.out_x  = out_x_r;
  assign out_if.out_y  = out_y_r;
  assign out_if.gate_x = gate_x_r;
  assign out_if.gate_y = gate_y_r;

endmodule

>>> rtl/core/xy_cv_smooth_quantize_core.sv
// ----------------------------------------------------------------------------
// xy_cv_smooth_quantize_core
// Two-axis CV generator: range map, offset, smoothing, semitone quantizer.
//
// Usage:
//   in_if   valid/ready channel, one control sample per item (positions,
//           offsets, range CVs, smoothness CV). Accepted when valid && ready.
//   out_if  valid/ready channel, one result item per input item: out_x,
//           out_y (volts Q12) and the note-change gates gate_x, gate_y.
//   cfg_*   register writes, taken on any edge with cfg_we high; write only
//           while no item is in flight.
//   Sequence: the coefficient unit runs first (reciprocal multiply, clamp,
//   index scale, ROM read), then both axis lanes run side by side, each
//   doing at most one multiply per step.
//   Only one item is in work at a time.
//   A finished result waits in the output register while the next item is
//   accepted; a lane result that finds that register still full holds until
//   the receiver takes the old one.
//   Reset: registers return to their defaults, smoother state clears, last
//   notes go to -1200 semitones; the coefficient ROM needs no init.
// ----------------------------------------------------------------------------
module xy_cv_smooth_quantize_core #(
  parameter int SAMPLE_RATE_HZ      = xycv_pkg::SAMPLE_RATE_DEF,
  parameter int ALPHA_TABLE_ENTRIES = xycv_pkg::ALPHA_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [xycv_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [xycv_pkg::CfgDataW-1:0] cfg_wdata,
  xycv_in_if.sink                       in_if,
  xycv_out_if.source                    out_if
);
  import xycv_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALPHA = 2'd1;
  localparam logic [1:0] ST_LANE  = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  // configuration registers
  logic [LevelW-1:0]       smooth_level_r;
  logic [QmodeW-1:0]       quantize_mode_r;
  logic signed [KnobW-1:0] x_lower_knob_r;
  logic signed [KnobW-1:0] x_upper_knob_r;
  logic signed [KnobW-1:0] y_lower_knob_r;
  logic signed [KnobW-1:0] y_upper_knob_r;
  logic [GateW-1:0]        gate_samples_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_level_r  <= '0;
      quantize_mode_r <= '0;
      x_lower_knob_r  <= '0;
      x_upper_knob_r  <= 17'sd40960;
      y_lower_knob_r  <= '0;
      y_upper_knob_r  <= 17'sd40960;
      gate_samples_r  <= 16'd480;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SMOOTH_LEVEL:  smooth_level_r  <= cfg_wdata[LevelW-1:0];
        CFG_QUANTIZE_MODE: quantize_mode_r <= cfg_wdata[QmodeW-1:0];
        CFG_X_LOWER_KNOB:  x_lower_knob_r  <= $signed(cfg_wdata[KnobW-1:0]);
        CFG_X_UPPER_KNOB:  x_upper_knob_r  <= $signed(cfg_wdata[KnobW-1:0]);
        CFG_Y_LOWER_KNOB:  y_lower_knob_r  <= $signed(cfg_wdata[KnobW-1:0]);
        CFG_Y_UPPER_KNOB:  y_upper_knob_r  <= $signed(cfg_wdata[KnobW-1:0]);
        CFG_GATE_SAMPLES:  gate_samples_r  <= cfg_wdata[GateW-1:0];
        default: ;
      endcase
    end
  end

  // sequencing
  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       alpha_go_r;
  logic       accept;
  logic       alpha_done;
  logic       lane_go;
  logic       done_x;
  logic       done_y;
  logic       free;
  logic       load;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign lane_go     = (state_r == ST_ALPHA) && alpha_done;
  assign load        = (((state_r == ST_LANE) && done_x && done_y) ||
                        (state_r == ST_WAIT)) && free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_ALPHA;
      ST_ALPHA: if (alpha_done) state_nxt = ST_LANE;
      ST_LANE: begin
        if (done_x && done_y) begin
          state_nxt = free ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT:  if (free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      alpha_go_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      alpha_go_r <= accept;
    end
  end

  // captured item
  logic [PosW-1:0]        pos_x_r;
  logic [PosW-1:0]        pos_y_r;
  logic signed [VinW-1:0] mod_x_r;
  logic signed [VinW-1:0] mod_y_r;
  logic signed [VinW-1:0] x_lower_cv_r;
  logic signed [VinW-1:0] x_upper_cv_r;
  logic signed [VinW-1:0] y_lower_cv_r;
  logic signed [VinW-1:0] y_upper_cv_r;
  logic signed [VinW-1:0] smooth_cv_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x_r      <= in_if.pos_x;
      pos_y_r      <= in_if.pos_y;
      mod_x_r      <= in_if.mod_x;
      mod_y_r      <= in_if.mod_y;
      x_lower_cv_r <= in_if.x_lower_cv;
      x_upper_cv_r <= in_if.x_upper_cv;
      y_lower_cv_r <= in_if.y_lower_cv;
      y_upper_cv_r <= in_if.y_upper_cv;
      smooth_cv_r  <= in_if.smooth_cv;
    end
  end

  // smoother coefficient, shared by both lanes
  logic [AlphaW-1:0] alpha;

  xycv_alpha_unit #(
    .SAMPLE_RATE_HZ      (SAMPLE_RATE_HZ),
    .ALPHA_TABLE_ENTRIES (ALPHA_TABLE_ENTRIES)
  ) u_alpha (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (alpha_go_r),
    .smooth_level (smooth_level_r),
    .smooth_cv    (smooth_cv_r),
    .alpha        (alpha),
    .done         (alpha_done)
  );

  // axis lanes
  lane_in_t  lane_x_in;
  lane_in_t  lane_y_in;
  lane_out_t lane_x_out;
  lane_out_t lane_y_out;

  always_comb begin
    lane_x_in.pos      = pos_x_r;
    lane_x_in.lo_knob  = x_lower_knob_r;
    lane_x_in.hi_knob  = x_upper_knob_r;
    lane_x_in.lo_cv    = x_lower_cv_r;
    lane_x_in.hi_cv    = x_upper_cv_r;
    lane_x_in.mod      = mod_x_r;
    lane_x_in.quant    = quantize_mode_r[0];
    lane_x_in.gate_len = gate_samples_r;

    lane_y_in.pos      = pos_y_r;
    lane_y_in.lo_knob  = y_lower_knob_r;
    lane_y_in.hi_knob  = y_upper_knob_r;
    lane_y_in.lo_cv    = y_lower_cv_r;
    lane_y_in.hi_cv    = y_upper_cv_r;
    lane_y_in.mod      = mod_y_r;
    lane_y_in.quant    = quantize_mode_r[1];
    lane_y_in.gate_len = gate_samples_r;
  end

  xycv_axis_lane u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lane_go),
    .lane_in (lane_x_in),
    .alpha   (alpha),
    .result  (lane_x_out),
    .done    (done_x)
  );

  xycv_axis_lane u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lane_go),
    .lane_in (lane_y_in),
    .alpha   (alpha),
    .result  (lane_y_out),
    .done    (done_y)
  );

  // result register
  xycv_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .lane_x (lane_x_out),
    .lane_y (lane_y_out),
    .free   (free),
    .out_if (out_if)
  );

endmodule

>>> rtl/core/xycv_checker.sv
// ----------------------------------------------------------------------------
// xycv_checker
// Port-level checks on item flow and result timing, bound to the core.
// ----------------------------------------------------------------------------
module xycv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [xycv_pkg::VoutW-1:0]   out_x,
  input logic signed [xycv_pkg::VoutW-1:0]   out_y,
  input logic                                gate_x,
  input logic                                gate_y
);

  // lag from accept to the sampled result, output register included
  localparam int ResultLag = 16;

  // one item in work: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is still in work");

  // every accepted item leaves a result waiting after ResultLag
  a_result_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##ResultLag out_valid)
    else $error("no result item present after the pipeline latency");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_x) && $stable(out_y) &&
       $stable(gate_x) && $stable(gate_y)))
    else $error("stalled result item changed");

endmodule

bind xy_cv_smooth_quantize_core xycv_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_x     (out_if.out_x),
  .out_y     (out_if.out_y),
  .gate_x    (out_if.gate_x),
  .gate_y    (out_if.gate_y)
);
